// ===== sv/bdme_pkg.sv =====
`default_nettype none
package bdme_pkg;

	localparam int BUTTONS        = 8;
	localparam int DATA_W         = 7;
	localparam int CHAN_W         = 4;
	localparam int CFG_INDEX_W    = 2;
	localparam int HISTORY_DEPTH_DEF = 4;
	localparam int QUEUE_DEPTH    = 2;

	// buttons whose release sends a message (0 and 1 only act on press)
	localparam logic [BUTTONS-1:0] RELEASE_MSG_MASK = 8'b1111_1100;

	localparam logic [DATA_W-1:0] NOTE_RESET      = 7'd64;
	localparam logic [DATA_W-1:0] PRESS_VEL_RESET = 7'd127;
	localparam logic [DATA_W-1:0] REL_VEL_RESET   = 7'd30;

	localparam int PROG_UP_BTN   = 0;
	localparam int PROG_DOWN_BTN = 1;
	localparam int NOTE_BTN      = 2;
	localparam int FIRST_CC_BTN  = 3;

	typedef enum logic [1:0] {
		KIND_PROGRAM  = 2'd0,
		KIND_NOTE_ON  = 2'd1,
		KIND_NOTE_OFF = 2'd2,
		KIND_CONTROL  = 2'd3
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CHANNEL   = 2'd0,
		REG_NOTE      = 2'd1,
		REG_PRESS_VEL = 2'd2,
		REG_REL_VEL   = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [DATA_W-1:0] note;
		logic [DATA_W-1:0] press_vel;
		logic [DATA_W-1:0] rel_vel;
	} cfg_t;

	// one debounced sample's worth of work: which buttons emit, and direction
	typedef struct packed {
		logic [BUTTONS-1:0] change;
		logic [BUTTONS-1:0] press;
	} event_t;

endpackage
`default_nettype wire

// ===== sv/bdme_front.sv =====
`default_nettype none
module bdme_front #(
	parameter int HISTORY_DEPTH = bdme_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [bdme_pkg::BUTTONS-1:0]  pin_levels,
	output bdme_pkg::event_t                   evt,
	output logic                               evt_push
);
	import bdme_pkg::*;

	localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	logic [BUTTONS-1:0] hist_q [HISTORY_DEPTH];
	logic [SLOT_W-1:0]  slot_q;
	logic [BUTTONS-1:0] stable_q;

	logic [BUTTONS-1:0] all_high;
	logic [BUTTONS-1:0] all_low;
	logic [BUTTONS-1:0] released;
	logic [BUTTONS-1:0] pressed;

	// history as it stands once this sample is written
	always_comb begin
		all_high = '1;
		all_low  = '1;
		for (int j = 0; j < HISTORY_DEPTH; j++) begin
			if (slot_q == SLOT_W'(j)) begin
				all_high = all_high & pin_levels;
				all_low  = all_low & ~pin_levels;
			end else begin
				all_high = all_high & hist_q[j];
				all_low  = all_low & ~hist_q[j];
			end
		end
	end

	assign released   = all_high & ~stable_q;
	assign pressed    = all_low & stable_q;
	assign evt.change = (released & RELEASE_MSG_MASK) | pressed;
	assign evt.press  = pressed;
	assign evt_push   = accept && (|evt.change);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < HISTORY_DEPTH; j++) begin
				hist_q[j] <= '0;
			end
			slot_q   <= '0;
			stable_q <= '0;
		end else if (accept) begin
			hist_q[slot_q] <= pin_levels;
			if (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
			stable_q <= (stable_q | all_high) & ~all_low;
		end
	end

endmodule
`default_nettype wire

// ===== sv/bdme_queue.sv =====
`default_nettype none
module bdme_queue (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr,
	input  wire bdme_pkg::event_t wr_data,
	output logic        full,
	input  wire logic   rd,
	output bdme_pkg::event_t rd_data,
	output logic        valid
);
	import bdme_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	event_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/bdme_back.sv =====
`default_nettype none
module bdme_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire bdme_pkg::cfg_t               cfg,
	input  wire logic                         q_valid,
	input  wire bdme_pkg::event_t             q_data,
	output logic                              q_pop,
	input  wire logic                         pop,
	output logic                              empty,
	output logic [1:0]                        msg_kind,
	output logic [bdme_pkg::CHAN_W-1:0]       channel,
	output logic [bdme_pkg::DATA_W-1:0]       data_first,
	output logic [bdme_pkg::DATA_W-1:0]       data_second,
	output logic                              last
);
	import bdme_pkg::*;

	localparam int IDX_W = $clog2(BUTTONS);

	logic [BUTTONS-1:0] cur_q;
	logic [BUTTONS-1:0] press_q;
	logic [DATA_W-1:0]  prog_q;
	logic               out_valid_q;

	logic [BUTTONS-1:0] lowbit;
	logic [BUTTONS-1:0] remaining;
	logic [BUTTONS-1:0] mask_next;
	logic [IDX_W-1:0]   idx;
	logic               emit;
	logic               is_press;
	kind_t              kind;
	logic [DATA_W-1:0]  d1;
	logic [DATA_W-1:0]  d2;
	logic [DATA_W-1:0]  prog_next;

	assign lowbit    = cur_q & (~cur_q + 1'b1);
	assign remaining = cur_q & ~lowbit;
	assign emit      = (|cur_q) && (!out_valid_q || pop);
	assign mask_next = emit ? remaining : cur_q;
	assign q_pop     = q_valid && (mask_next == '0);

	always_comb begin
		idx = '0;
		for (int i = 0; i < BUTTONS; i++) begin
			if (lowbit[i]) begin
				idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		is_press  = |(press_q & lowbit);
		prog_next = prog_q;
		kind      = KIND_CONTROL;
		d1        = DATA_W'(idx - IDX_W'(FIRST_CC_BTN));
		d2        = {{(DATA_W-1){1'b0}}, is_press};
		case (idx)
			IDX_W'(PROG_UP_BTN): begin
				prog_next = prog_q + 1'b1;
				kind      = KIND_PROGRAM;
				d1        = prog_next;
				d2        = '0;
			end
			IDX_W'(PROG_DOWN_BTN): begin
				prog_next = prog_q - 1'b1;
				kind      = KIND_PROGRAM;
				d1        = prog_next;
				d2        = '0;
			end
			IDX_W'(NOTE_BTN): begin
				kind = is_press ? KIND_NOTE_ON : KIND_NOTE_OFF;
				d1   = cfg.note;
				d2   = is_press ? cfg.press_vel : cfg.rel_vel;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			press_q     <= '0;
			prog_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_q   <= q_data.change;
				press_q <= q_data.press;
			end else begin
				cur_q <= mask_next;
			end
			if (emit) begin
				prog_q      <= prog_next;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			msg_kind    <= kind;
			channel     <= cfg.channel;
			data_first  <= d1;
			data_second <= d2;
			last        <= (remaining == '0);
		end
	end

	assign empty = !out_valid_q;

endmodule
`default_nettype wire

// ===== sv/button_debounce_midi_events.sv =====
`default_nettype none
// Eight-button debouncer that speaks MIDI. Each beat pushed in is one sample of
// eight active-low switch pins; the block keeps the last HISTORY_DEPTH samples
// and treats a button as settled only when all of them agree. Each settled
// change, button 0 first, pops out as one MIDI message beat: buttons 0/1 step
// the program number up/down (wrapping within 0..127) on press, button 2 sends
// note on/off, buttons 3..7 send controllers 0..4 with value 1/0. The last
// message of a sample carries last=1; a sample with no settled change yields
// nothing. Throughput: a sample is taken every cycle while the two-entry event
// queue has room, and the message engine emits one message per cycle while pop
// keeps taking them; one sample can cause up to 8 messages. A sample's events
// pass through the event queue, the back end's event mask and the output
// register. Registers (wr_index): 0 channel, 1 note number, 2 press velocity,
// 3 release velocity; write them only while the block is idle.
module button_debounce_midi_events #(
	parameter int HISTORY_DEPTH = bdme_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// sample side
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [bdme_pkg::BUTTONS-1:0]      pin_levels,
	// message side
	output logic                                   empty,
	input  wire logic                              pop,
	output logic [1:0]                             msg_kind,
	output logic [bdme_pkg::CHAN_W-1:0]            channel,
	output logic [bdme_pkg::DATA_W-1:0]            data_first,
	output logic [bdme_pkg::DATA_W-1:0]            data_second,
	output logic                                   last,
	// register writes
	input  wire logic                              wr_en,
	input  wire logic [bdme_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  wire logic [bdme_pkg::DATA_W-1:0]       wr_data
);
	import bdme_pkg::*;

	cfg_t   cfg_q;
	event_t evt;
	event_t q_data;
	logic   accept;
	logic   evt_push;
	logic   q_full;
	logic   q_valid;
	logic   q_pop;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel   <= '0;
			cfg_q.note      <= NOTE_RESET;
			cfg_q.press_vel <= PRESS_VEL_RESET;
			cfg_q.rel_vel   <= REL_VEL_RESET;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_CHANNEL:   cfg_q.channel   <= wr_data[CHAN_W-1:0];
				REG_NOTE:      cfg_q.note      <= wr_data;
				REG_PRESS_VEL: cfg_q.press_vel <= wr_data;
				REG_REL_VEL:   cfg_q.rel_vel   <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// front: takes a sample whenever the queue can hold its events
	assign full   = q_full;
	assign accept = push && !q_full;

	bdme_front #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pin_levels(pin_levels),
		.evt       (evt),
		.evt_push  (evt_push)
	);

	bdme_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (evt_push),
		.wr_data(evt),
		.full   (q_full),
		.rd     (q_pop),
		.rd_data(q_data),
		.valid  (q_valid)
	);

	// back: walks each event mask lowest button first into the output register
	bdme_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.msg_kind   (msg_kind),
		.channel    (channel),
		.data_first (data_first),
		.data_second(data_second),
		.last       (last)
	);

endmodule
`default_nettype wire
